// ===== rtl/rv64alu_pkg.sv =====
// Package with operation codes and pipeline constants for the RV64IM execute unit.
package rv64alu_pkg;

   typedef enum logic [4:0] {
      OP_ADD    = 5'd0,
      OP_ADDW   = 5'd1,
      OP_SUB    = 5'd2,
      OP_SUBW   = 5'd3,
      OP_AND    = 5'd4,
      OP_OR     = 5'd5,
      OP_XOR    = 5'd6,
      OP_SLL    = 5'd7,
      OP_SLLW   = 5'd8,
      OP_SRL    = 5'd9,
      OP_SRLW   = 5'd10,
      OP_SRA    = 5'd11,
      OP_SRAW   = 5'd12,
      OP_SLT    = 5'd13,
      OP_SLTU   = 5'd14,
      OP_MUL    = 5'd15,
      OP_MULW   = 5'd16,
      OP_MULH   = 5'd17,
      OP_MULHSU = 5'd18,
      OP_MULHU  = 5'd19,
      OP_DIV    = 5'd20,
      OP_DIVU   = 5'd21,
      OP_DIVW   = 5'd22,
      OP_DIVUW  = 5'd23,
      OP_REM    = 5'd24,
      OP_REMU   = 5'd25,
      OP_REMW   = 5'd26,
      OP_REMUW  = 5'd27
   } op_type;

   localparam int XLEN = 64;
   localparam int DIV_STEPS = XLEN;
   localparam int MUL_DONE = 4;
   localparam int DEPTH = DIV_STEPS + 2;
   localparam logic [31:0] LOW32 = 32'hffffffff;

   function automatic logic [63:0] sext32(input logic [63:0] x);
      sext32 = {{32{x[31]}}, x[31:0]};
   endfunction

endpackage

// ===== rtl/rv64_integer_alu_with_muldiv_top.sv =====
// Top level of the pipelined RV64IM integer execute unit.
// Each input beat on the req_ channel carries an operation code and two 64-bit
// operands; each beat on the rsp_ channel carries one 64-bit result, in order.
// The unit is one pipeline of 66 register stages. Stage zero decodes the
// operation, computes all add, logic, shift and compare operations and
// prepares the operands. The multiplier forms four 32x32 partial products
// and sums them over the next stages. The divider is a restoring divider
// with one quotient bit per stage, 64 stages, which sets the depth of the
// pipeline. The last stage fixes signs and special cases and is the output
// register. Every operation passes through all stages to rsp_valid. The unit
// takes one beat per cycle while the receiver does not stall. When the
// receiver stalls, the whole pipeline holds and req_ready falls; no beat is
// lost or repeated. Reset clears all valid bits; no other register is reset.
module rv64_integer_alu_with_muldiv_top
   import rv64alu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_type,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result
);

   localparam int LAST = DEPTH - 1;

   logic              en;
   logic              valid_ff [DEPTH];
   op_type            op_ff    [DEPTH];
   logic [63:0]       res_ff   [DEPTH];
   logic [63:0]       rem_ff   [DEPTH-1];
   logic [63:0]       quo_ff   [DEPTH-1];
   logic [63:0]       dvs_ff   [DEPTH-1];
   logic              negq_ff  [DEPTH-1];
   logic              negr_ff  [DEPTH-1];
   logic              dz_ff    [DEPTH-1];

   logic [63:0]       corr_ff  [MUL_DONE];
   logic [63:0]       ma_ff, mb_ff;
   logic [63:0]       ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0]      s1_ff, s2_ff, prod_ff;

   op_type            op_in;
   logic [63:0]       res_in;
   logic [63:0]       corr_in;
   logic [63:0]       da, db, dmag_a, dmag_b;
   logic              div_signed, div_word;
   logic [5:0]        sh6;
   logic [4:0]        sh5;
   logic [63:0]       sraw_tmp;
   logic [63:0]       rem_in  [DEPTH-1];
   logic [63:0]       quo_in  [DEPTH-1];
   logic [63:0]       mul_res;
   logic [63:0]       q_fix, r_fix, final_in;

   assign en        = !valid_ff[LAST] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[LAST];
   assign rsp_result = res_ff[LAST];

   assign op_in = op_type'(req_type);
   assign sh6 = req_operand_b[5:0];
   assign sh5 = req_operand_b[4:0];
   assign sraw_tmp = $unsigned($signed(sext32(req_operand_a)) >>> sh5);

   always_comb begin
      case (op_in)
         OP_ADD:  res_in = req_operand_a + req_operand_b;
         OP_ADDW: res_in = sext32(req_operand_a + req_operand_b);
         OP_SUB:  res_in = req_operand_a - req_operand_b;
         OP_SUBW: res_in = sext32(req_operand_a - req_operand_b);
         OP_AND:  res_in = req_operand_a & req_operand_b;
         OP_OR:   res_in = req_operand_a | req_operand_b;
         OP_XOR:  res_in = req_operand_a ^ req_operand_b;
         OP_SLL:  res_in = req_operand_a << sh6;
         OP_SLLW: res_in = sext32({32'd0, req_operand_a[31:0]} << sh5);
         OP_SRL:  res_in = req_operand_a >> sh6;
         OP_SRLW: res_in = sext32({32'd0, req_operand_a[31:0]} >> sh5);
         OP_SRA:  res_in = $unsigned($signed(req_operand_a) >>> sh6);
         OP_SRAW: res_in = sext32(sraw_tmp);
         OP_SLT:  res_in = {63'd0, $signed(req_operand_a) < $signed(req_operand_b)};
         OP_SLTU: res_in = {63'd0, req_operand_a < req_operand_b};
         default: res_in = 64'd0;
      endcase
   end

   always_comb begin
      case (op_in)
         OP_MULH:   corr_in = (req_operand_a[63] ? req_operand_b : 64'd0)
                            + (req_operand_b[63] ? req_operand_a : 64'd0);
         OP_MULHSU: corr_in = req_operand_a[63] ? req_operand_b : 64'd0;
         default:   corr_in = 64'd0;
      endcase
   end

   assign div_signed = (op_in == OP_DIV) || (op_in == OP_DIVW) ||
                       (op_in == OP_REM) || (op_in == OP_REMW);
   assign div_word   = (op_in == OP_DIVW) || (op_in == OP_DIVUW) ||
                       (op_in == OP_REMW) || (op_in == OP_REMUW);

   always_comb begin
      if (div_word) begin
         da = div_signed ? sext32(req_operand_a) : {32'd0, req_operand_a[31:0]};
         db = div_signed ? sext32(req_operand_b) : {32'd0, req_operand_b[31:0]};
      end else begin
         da = req_operand_a;
         db = req_operand_b;
      end
      dmag_a = (div_signed && da[63]) ? (64'd0 - da) : da;
      dmag_b = (div_signed && db[63]) ? (64'd0 - db) : db;
   end

   always_comb begin
      logic [64:0] rsh;
      logic        ge;
      for (int i = 1; i < DEPTH - 1; i++) begin
         rsh = {rem_ff[i-1], quo_ff[i-1][63]};
         ge = rsh >= {1'b0, dvs_ff[i-1]};
         rem_in[i] = ge ? 64'(rsh - {1'b0, dvs_ff[i-1]}) : rsh[63:0];
         quo_in[i] = {quo_ff[i-1][62:0], ge};
      end
      rem_in[0] = 64'd0;
      quo_in[0] = dmag_a;
   end

   always_comb begin
      case (op_ff[MUL_DONE-1])
         OP_MUL:    mul_res = prod_ff[63:0];
         OP_MULW:   mul_res = sext32(prod_ff[63:0]);
         OP_MULH, OP_MULHSU, OP_MULHU:
                    mul_res = prod_ff[127:64] - corr_ff[MUL_DONE-1];
         default:   mul_res = res_ff[MUL_DONE-1];
      endcase
   end

   always_comb begin
      q_fix = negq_ff[LAST-1] ? (64'd0 - quo_ff[LAST-1]) : quo_ff[LAST-1];
      if (dz_ff[LAST-1]) begin
         q_fix = '1;
      end
      r_fix = negr_ff[LAST-1] ? (64'd0 - rem_ff[LAST-1]) : rem_ff[LAST-1];
      case (op_ff[LAST-1])
         OP_DIV, OP_DIVU:   final_in = q_fix;
         OP_DIVW, OP_DIVUW: final_in = sext32(q_fix);
         OP_REM, OP_REMU:   final_in = r_fix;
         OP_REMW, OP_REMUW: final_in = sext32(r_fix);
         default:           final_in = res_ff[LAST-1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff[0]   <= op_in;
         res_ff[0]  <= res_in;
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         dvs_ff[0]  <= dmag_b;
         negq_ff[0] <= div_signed && (da[63] ^ db[63]);
         negr_ff[0] <= div_signed && da[63];
         dz_ff[0]   <= db == 64'd0;
         corr_ff[0] <= corr_in;
         ma_ff      <= req_operand_a;
         mb_ff      <= req_operand_b;
         for (int i = 1; i < DEPTH; i++) begin
            op_ff[i] <= op_ff[i-1];
         end
         for (int i = 1; i < DEPTH - 1; i++) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            dvs_ff[i]  <= dvs_ff[i-1];
            negq_ff[i] <= negq_ff[i-1];
            negr_ff[i] <= negr_ff[i-1];
            dz_ff[i]   <= dz_ff[i-1];
         end
         for (int i = 1; i < MUL_DONE; i++) begin
            corr_ff[i] <= corr_ff[i-1];
         end
         for (int i = 1; i < DEPTH - 1; i++) begin
            if (i == MUL_DONE) begin
               res_ff[i] <= mul_res;
            end else begin
               res_ff[i] <= res_ff[i-1];
            end
         end
         res_ff[LAST] <= final_in;
         ll_ff   <= ma_ff[31:0] * mb_ff[31:0];
         lh_ff   <= ma_ff[31:0] * mb_ff[63:32];
         hl_ff   <= ma_ff[63:32] * mb_ff[31:0];
         hh_ff   <= ma_ff[63:32] * mb_ff[63:32];
         s1_ff   <= {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0};
         s2_ff   <= {hh_ff, 64'd0} + {32'd0, hl_ff, 32'd0};
         prod_ff <= s1_ff + s2_ff;
      end
   end

endmodule
